// ===== rtl/rpt_pkg.sv =====
// Shared constants, types and helper functions for the raw pulse text parser.
`timescale 1ns / 1ps

package rpt_pkg;

    localparam int DURATION_BITS = 31;
    localparam int ACC_BITS      = DURATION_BITS + 4;
    localparam int KEY_BITS      = 4;

    localparam logic [KEY_BITS-1:0] KEY_LENGTH = 4'd9;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_COMMA = 8'h2C;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_R     = 8'h52;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       end_of_stream;
    } item_t;

    typedef struct packed {
        logic                     has_pulse;
        logic                     pulse_level;
        logic [DURATION_BITS-1:0] pulse_duration;
        logic                     finished;
    } result_t;

    // Characters of the data line key by position.
    function automatic logic [7:0] key_char(input logic [KEY_BITS-1:0] idx);
        logic [7:0] ch;
        unique case (idx)
            4'd0:    ch = 8'h52;
            4'd1:    ch = 8'h41;
            4'd2:    ch = 8'h57;
            4'd3:    ch = 8'h5F;
            4'd4:    ch = 8'h44;
            4'd5:    ch = 8'h61;
            4'd6:    ch = 8'h74;
            4'd7:    ch = 8'h61;
            4'd8:    ch = 8'h3A;
            default: ch = 8'h52;
        endcase
        return ch;
    endfunction

endpackage

// ===== rtl/raw_pulse_text_parser.sv =====
// Top level of the raw pulse text parser: input register, parser core, result register.
`timescale 1ns / 1ps

// The parser takes one text byte per word and sustains one word per clock cycle while
// no result is stalled at the output. A word passes an input register, is parsed
// combinationally against the held line state, and any result lands in a result register,
// from which it is offered to the sink and held until out_ready takes it. A result stalled
// at the output holds the parser but the input register still takes one more word.
// Lines open after the data line key; each signed decimal number on them gives one word
// with its level and saturated magnitude, and an end-of-stream word always gives one
// word marked finished.
module raw_pulse_text_parser
    import rpt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [7:0]               text_byte,
    input  logic                     end_of_stream,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     has_pulse,
    output logic                     pulse_level,
    output logic [DURATION_BITS-1:0] pulse_duration,
    output logic                     finished
);

    logic    item_valid;
    item_t   item;
    logic    advance;
    logic    emit;
    result_t res;

    rpt_in_stage u_in_stage
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .text_byte     (text_byte),
        .end_of_stream (end_of_stream),
        .advance       (advance),
        .item_valid    (item_valid),
        .item          (item)
    );

    rpt_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .process (item_valid && advance),
        .item    (item),
        .emit    (emit),
        .res     (res)
    );

    rpt_out_stage u_out_stage
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .emit           (emit),
        .res            (res),
        .advance        (advance),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .has_pulse      (has_pulse),
        .pulse_level    (pulse_level),
        .pulse_duration (pulse_duration),
        .finished       (finished)
    );

endmodule

// ===== rtl/rpt_in_stage.sv =====
// Input register that holds one accepted text word until the parser takes it.
`timescale 1ns / 1ps

module rpt_in_stage
    import rpt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] text_byte,
    input  logic       end_of_stream,
    input  logic       advance,
    output logic       item_valid,
    output item_t      item
);

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  load;

    assign in_ready   = !valid_reg || advance;
    assign load       = in_valid && in_ready;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg.text_byte     <= text_byte;
            item_reg.end_of_stream <= end_of_stream;
        end
    end

endmodule

// ===== rtl/rpt_core.sv =====
// Parser state and the per-word key match, number scan and pulse decision.
`timescale 1ns / 1ps

module rpt_core
    import rpt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    process,
    input  item_t   item,
    output logic    emit,
    output result_t res
);

    localparam logic [ACC_BITS-1:0] MAX_MAG = {{(ACC_BITS-DURATION_BITS){1'b0}},
                                               {DURATION_BITS{1'b1}}};

    logic [KEY_BITS-1:0]      key_count_reg;
    logic [KEY_BITS-1:0]      key_count_next;
    logic                     inside_reg;
    logic                     inside_next;
    logic                     minus_reg;
    logic                     minus_next;
    logic                     sign_seen_reg;
    logic                     sign_seen_next;
    logic                     digits_seen_reg;
    logic                     digits_seen_next;
    logic [DURATION_BITS-1:0] acc_reg;
    logic [DURATION_BITS-1:0] acc_next;

    logic [7:0]               ch;
    logic [KEY_BITS-1:0]      key_idx;
    logic [KEY_BITS-1:0]      key_idx_inc;
    logic                     is_digit;
    logic                     is_sep;
    logic                     is_sign;
    logic                     no_number;
    logic [ACC_BITS-1:0]      acc_wide;
    logic [ACC_BITS-1:0]      product;
    logic [DURATION_BITS-1:0] acc_step;
    result_t                  pulse_res;

    assign ch          = item.text_byte;
    assign key_idx     = (key_count_reg < KEY_LENGTH) ? key_count_reg : '0;
    assign key_idx_inc = key_idx + 1'b1;
    assign is_digit    = (ch >= CHAR_ZERO) && (ch <= CHAR_NINE);
    assign is_sep      = (ch == CHAR_SPACE) || (ch == CHAR_TAB) || (ch == CHAR_COMMA);
    assign is_sign     = (ch == CHAR_MINUS) || (ch == CHAR_PLUS);
    assign no_number   = !sign_seen_reg && !digits_seen_reg;

    // The accumulator grows by times ten plus the digit and saturates at full scale.
    assign acc_wide = {{(ACC_BITS-DURATION_BITS){1'b0}}, acc_reg};
    assign product  = (acc_wide << 3) + (acc_wide << 1)
                    + {{(ACC_BITS-4){1'b0}}, ch[3:0]};
    assign acc_step = (product > MAX_MAG) ? MAX_MAG[DURATION_BITS-1:0]
                                          : product[DURATION_BITS-1:0];

    // A minus zero still counts as a high level.
    always_comb
    begin
        pulse_res.has_pulse      = 1'b1;
        pulse_res.pulse_level    = !minus_reg || (acc_reg == '0);
        pulse_res.pulse_duration = acc_reg;
        pulse_res.finished       = 1'b0;
    end

    always_comb
    begin
        key_count_next   = key_count_reg;
        inside_next      = inside_reg;
        minus_next       = minus_reg;
        sign_seen_next   = sign_seen_reg;
        digits_seen_next = digits_seen_reg;
        acc_next         = acc_reg;
        emit             = 1'b0;
        res              = '0;
        if (process)
        begin
            priority if (item.end_of_stream)
            begin
                emit = 1'b1;
                if (inside_reg && digits_seen_reg)
                begin
                    res = pulse_res;
                end
                res.finished     = 1'b1;
                key_count_next   = '0;
                inside_next      = 1'b0;
                minus_next       = 1'b0;
                sign_seen_next   = 1'b0;
                digits_seen_next = 1'b0;
                acc_next         = '0;
            end
            else if (!inside_reg)
            begin
                if (ch == key_char(key_idx))
                begin
                    if (key_idx_inc >= KEY_LENGTH)
                    begin
                        inside_next      = 1'b1;
                        key_count_next   = '0;
                        minus_next       = 1'b0;
                        sign_seen_next   = 1'b0;
                        digits_seen_next = 1'b0;
                        acc_next         = '0;
                    end
                    else
                    begin
                        key_count_next = key_idx_inc;
                    end
                end
                else
                begin
                    key_count_next = (ch == CHAR_R) ? KEY_BITS'(1) : '0;
                end
            end
            else if (ch == CHAR_CR)
            begin
                key_count_next = key_count_reg;
            end
            else if (ch == CHAR_LF)
            begin
                inside_next    = 1'b0;
                key_count_next = '0;
                if (digits_seen_reg)
                begin
                    emit = 1'b1;
                    res  = pulse_res;
                end
                minus_next       = 1'b0;
                sign_seen_next   = 1'b0;
                digits_seen_next = 1'b0;
                acc_next         = '0;
            end
            else if (no_number && is_sep)
            begin
                key_count_next = key_count_reg;
            end
            else if (no_number && is_sign)
            begin
                minus_next     = (ch == CHAR_MINUS);
                sign_seen_next = 1'b1;
            end
            else if (is_digit)
            begin
                acc_next         = acc_step;
                digits_seen_next = 1'b1;
            end
            else if (digits_seen_reg)
            begin
                emit             = 1'b1;
                res              = pulse_res;
                minus_next       = 1'b0;
                sign_seen_next   = 1'b0;
                digits_seen_next = 1'b0;
                acc_next         = '0;
            end
            else
            begin
                minus_next     = 1'b0;
                sign_seen_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg   <= '0;
            inside_reg      <= 1'b0;
            minus_reg       <= 1'b0;
            sign_seen_reg   <= 1'b0;
            digits_seen_reg <= 1'b0;
            acc_reg         <= '0;
        end
        else
        begin
            key_count_reg   <= key_count_next;
            inside_reg      <= inside_next;
            minus_reg       <= minus_next;
            sign_seen_reg   <= sign_seen_next;
            digits_seen_reg <= digits_seen_next;
            acc_reg         <= acc_next;
        end
    end

    // The key count rests at zero for the whole time a data line is open.
    a_key_idle_in_line: assert property (@(posedge clk) disable iff (!rst_n)
        inside_reg |-> key_count_reg == '0)
        else $error("key count moved inside a data line");

    a_minus_needs_sign: assert property (@(posedge clk) disable iff (!rst_n)
        minus_reg |-> sign_seen_reg)
        else $error("minus flag set without a sign");

    a_acc_needs_digits: assert property (@(posedge clk) disable iff (!rst_n)
        !digits_seen_reg |-> acc_reg == '0)
        else $error("magnitude pending without digits");

    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && res.finished) |=> (!inside_reg && !digits_seen_reg
                                    && key_count_reg == '0))
        else $error("state not cleared after end of stream");

endmodule

// ===== rtl/rpt_out_stage.sv =====
// Result register that holds one finished result word until the sink takes it.
`timescale 1ns / 1ps

module rpt_out_stage
    import rpt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    input  logic                     emit,
    input  result_t                  res,
    output logic                     advance,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic                     has_pulse,
    output logic                     pulse_level,
    output logic [DURATION_BITS-1:0] pulse_duration,
    output logic                     finished
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;
    logic    load;

    assign advance = !valid_reg || out_ready;
    assign load    = item_valid && advance && emit;

    assign out_valid      = valid_reg;
    assign has_pulse      = res_reg.has_pulse;
    assign pulse_level    = res_reg.pulse_level;
    assign pulse_duration = res_reg.pulse_duration;
    assign finished       = res_reg.finished;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

endmodule
